@@ rtl/bce_pkg.sv @@
// Shared types, constants and the charge curve of the battery charge estimator.
package bce_pkg;

   localparam int SampleCount = 5;
   localparam int SampleWidth = 11;
   localparam int RefWidth    = 13;
   localparam int FsWidth     = 12;
   localparam int GainWidth   = 4;
   localparam int PctWidth    = 7;
   localparam int MvWidth     = 16;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 13;
   localparam int CurvePoints = 10;
   localparam int QuotWidth   = 24;

   localparam logic [CsrAddrWidth-1:0] CsrRefMv    = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CsrFullScale = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CsrGain     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV,
      ST_MV,
      ST_INTERP,
      ST_IDIV,
      ST_OUT
   } state_type;

   function automatic logic [MvWidth-1:0] curve_mv(input logic [3:0] idx);
      logic [MvWidth-1:0] v;
      case (idx)
         4'd0: v = 16'd3300;
         4'd1: v = 16'd3500;
         4'd2: v = 16'd3600;
         4'd3: v = 16'd3700;
         4'd4: v = 16'd3750;
         4'd5: v = 16'd3800;
         4'd6: v = 16'd3900;
         4'd7: v = 16'd4000;
         4'd8: v = 16'd4100;
         default: v = 16'd4200;
      endcase
      return v;
   endfunction

   function automatic logic [PctWidth-1:0] curve_pct(input logic [3:0] idx);
      logic [PctWidth-1:0] v;
      case (idx)
         4'd0: v = 7'd0;
         4'd1: v = 7'd5;
         4'd2: v = 7'd10;
         4'd3: v = 7'd20;
         4'd4: v = 7'd35;
         4'd5: v = 7'd50;
         4'd6: v = 7'd70;
         4'd7: v = 7'd85;
         4'd8: v = 7'd95;
         default: v = 7'd100;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/bce_rank_lane.sv @@
// One lane: counts how many samples rank below its own sample.
module bce_rank_lane #(
   parameter int SAMPLE_COUNT = bce_pkg::SampleCount,
   parameter int LANE = 0
) (
   input  logic [SAMPLE_COUNT-1:0][bce_pkg::SampleWidth-1:0] samples,
   output logic [$clog2(SAMPLE_COUNT+1)-1:0]                 rank
);
   localparam int RankWidth = $clog2(SAMPLE_COUNT + 1);

   // Ties are broken by position so every lane gets a distinct rank.
   always_comb begin
      rank = '0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
         if (j != LANE) begin
            if ((samples[j] < samples[LANE]) ||
                ((samples[j] == samples[LANE]) && (j < LANE))) begin
               rank = rank + RankWidth'(1);
            end
         end
      end
   end
endmodule

@@ rtl/bce_median.sv @@
// Parallel rank lanes and the merge that picks the median sample.
module bce_median #(
   parameter int SAMPLE_COUNT = bce_pkg::SampleCount
) (
   input  logic                                              clock,
   input  logic [SAMPLE_COUNT-1:0][bce_pkg::SampleWidth-1:0] samples,
   output logic [bce_pkg::SampleWidth-1:0]                   median
);
   localparam int RankWidth = $clog2(SAMPLE_COUNT + 1);
   localparam int MidRank   = SAMPLE_COUNT / 2;

   logic [SAMPLE_COUNT-1:0][RankWidth-1:0] rank;
   logic [SAMPLE_COUNT-1:0][RankWidth-1:0] rank_ff;
   logic [SAMPLE_COUNT-1:0][bce_pkg::SampleWidth-1:0] samp_ff;
   logic [bce_pkg::SampleWidth-1:0] median_in;

   for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_lane
      bce_rank_lane #(.SAMPLE_COUNT(SAMPLE_COUNT), .LANE(g)) u_lane (
         .samples(samples),
         .rank   (rank[g])
      );
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank;
      samp_ff <= samples;
   end

   always_comb begin
      median_in = '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         if (rank_ff[i] == RankWidth'(MidRank)) begin
            median_in = median_in | samp_ff[i];
         end
      end
   end

   assign median = median_in;
endmodule

@@ rtl/bce_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module bce_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bce_pkg::QuotWidth-1:0]  dividend,
   input  logic [bce_pkg::MvWidth-1:0]    divisor,
   output logic                           done,
   output logic [bce_pkg::QuotWidth-1:0]  quotient
);
   localparam int W = bce_pkg::QuotWidth;
   localparam int CntWidth = $clog2(W + 1);

   logic [W-1:0]            quot_ff, quot_in;
   logic [bce_pkg::MvWidth:0] rem_ff, rem_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [bce_pkg::MvWidth:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[bce_pkg::MvWidth-1:0], quot_ff[W-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CntWidth'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in  = trial - {1'b0, divisor};
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntWidth'(1);
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule

@@ rtl/battery_charge_estimator.sv @@
// Top level of the battery charge estimator.
//
//  Channel | Ports                          | Direction
//  req     | req_valid/req_stall, samples   | in
//  rsp     | rsp_valid/rsp_stall, percent   | out
//  csr     | csr_write, csr_index, csr_data | in
//
// A valid reading passes the scaling product, the scaling divider and a walk of up to
// ten curve points at one a cycle, and inside the curve the interpolation quotient,
// before its result is loaded. A zero gain or full scale skips the divider.
// A failed read goes straight to the output. One item is in work at a time, and the
// next beat is taken on the cycle after the result is loaded.
// Reset is synchronous, clears the state and loads the configuration registers with defaults.
// While a result beat is stalled the next item is still taken into work.
module battery_charge_estimator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bce_pkg::SampleWidth-1:0]     req_sample_0,
   input  logic [bce_pkg::SampleWidth-1:0]     req_sample_1,
   input  logic [bce_pkg::SampleWidth-1:0]     req_sample_2,
   input  logic [bce_pkg::SampleWidth-1:0]     req_sample_3,
   input  logic [bce_pkg::SampleWidth-1:0]     req_sample_4,
   input  logic                                req_read_failed,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bce_pkg::PctWidth-1:0]        rsp_charge_percent,
   input  logic                                csr_write,
   input  logic [bce_pkg::CsrAddrWidth-1:0]    csr_index,
   input  logic [bce_pkg::CsrDataWidth-1:0]    csr_data
);
   localparam int PW = bce_pkg::PctWidth;
   localparam int MW = bce_pkg::MvWidth;
   localparam int QW = bce_pkg::QuotWidth;

   logic [bce_pkg::RefWidth-1:0]  ref_ff;
   logic [bce_pkg::FsWidth-1:0]   fs_ff;
   logic [bce_pkg::GainWidth-1:0] gain_ff;

   logic [PW-1:0] smooth_ff, smooth_in;
   logic          have_ff, have_in;
   bce_pkg::state_type state_ff, state_in;

   logic [bce_pkg::SampleCount-1:0][bce_pkg::SampleWidth-1:0] req_samples;
   logic [bce_pkg::SampleWidth-1:0] median;
   logic [QW-1:0] prod_ff, prod_in;
   logic [MW-1:0] mv_ff, mv_in;
   logic [3:0]    seg_ff, seg_in;
   logic [PW-1:0] base_ff, base_in;

   logic          div_start;
   logic [QW-1:0] div_dividend;
   logic [MW-1:0] div_divisor;
   logic          div_done;
   logic [QW-1:0] div_quot;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pct_ff, rsp_pct_in;
   logic          req_take;
   logic          out_free;
   logic [PW+1:0] mix;
   logic [PW-1:0] pct;
   logic [QW+3:0] mv_full;
   logic [MW-1:0] off;
   logic [MW-1:0] span;
   logic [11:0]   numer;
   logic [21:0]   recip;

   assign req_samples = {req_sample_4, req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   // The lanes register their ranks at the accepting edge, so the median is
   // ready in the cycle after the beat.
   bce_median #(.SAMPLE_COUNT(bce_pkg::SampleCount)) u_median (
      .clock  (clock),
      .samples(req_samples),
      .median (median)
   );

   bce_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff  <= bce_pkg::RefWidth'(3300);
         fs_ff   <= bce_pkg::FsWidth'(2047);
         gain_ff <= bce_pkg::GainWidth'(2);
      end else if (csr_write) begin
         unique case (csr_index)
            bce_pkg::CsrRefMv:     ref_ff  <= csr_data;
            bce_pkg::CsrFullScale: fs_ff   <= csr_data[bce_pkg::FsWidth-1:0];
            bce_pkg::CsrGain:      gain_ff <= csr_data[bce_pkg::GainWidth-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != bce_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      smooth_in    = smooth_ff;
      have_in      = have_ff;
      prod_in      = prod_ff;
      mv_in        = mv_ff;
      seg_in       = seg_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pct_in   = rsp_pct_ff;
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = {4'd0, fs_ff};
      mv_full      = (QW + 4)'(div_quot) * (QW + 4)'(gain_ff);
      off          = mv_ff - bce_pkg::curve_mv(seg_ff - 4'd1);
      span         = '0;
      numer        = '0;
      recip        = '0;
      pct          = '0;
      mix          = '0;
      unique case (state_ff)
         bce_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_read_failed) begin
                  smooth_in = have_ff ? smooth_ff : '0;
                  state_in  = bce_pkg::ST_OUT;
               end else begin
                  state_in = bce_pkg::ST_SCALE;
               end
            end
         end
         bce_pkg::ST_SCALE: begin
            prod_in  = QW'(median) * QW'(ref_ff);
            state_in = bce_pkg::ST_DIV;
         end
         bce_pkg::ST_DIV: begin
            if (gain_ff == '0) begin
               mv_in    = '0;
               seg_in   = 4'd0;
               state_in = bce_pkg::ST_INTERP;
            end else if (fs_ff == '0) begin
               mv_in    = '1;
               seg_in   = 4'd0;
               state_in = bce_pkg::ST_INTERP;
            end else begin
               div_start = 1'b1;
               state_in  = bce_pkg::ST_MV;
            end
         end
         bce_pkg::ST_MV: begin
            if (div_done) begin
               mv_in    = (mv_full > (QW + 4)'(16'hFFFF)) ? '1 : mv_full[MW-1:0];
               seg_in   = 4'd0;
               state_in = bce_pkg::ST_INTERP;
            end
         end
         bce_pkg::ST_INTERP: begin
            // Walk the curve one point a cycle to find the segment.
            if (seg_ff == 4'd0 && mv_ff <= bce_pkg::curve_mv(4'd0)) begin
               pct      = bce_pkg::curve_pct(4'd0);
               state_in = bce_pkg::ST_OUT;
            end else if (seg_ff == 4'd0) begin
               seg_in = 4'd1;
            end else if (mv_ff <= bce_pkg::curve_mv(seg_ff)) begin
               base_in = bce_pkg::curve_pct(seg_ff - 4'd1);
               span    = bce_pkg::curve_mv(seg_ff) - bce_pkg::curve_mv(seg_ff - 4'd1);
               numer   = 12'(off) * 12'(bce_pkg::curve_pct(seg_ff)
                         - bce_pkg::curve_pct(seg_ff - 4'd1)) + 12'(span >> 1);
               // Every span is 50, 100 or 200, so a shift leaves a division by 25.
               case (span)
                  16'd200: prod_in = QW'(numer >> 3);
                  16'd100: prod_in = QW'(numer >> 2);
                  default: prod_in = QW'(numer >> 1);
               endcase
               state_in = bce_pkg::ST_IDIV;
            end else if (seg_ff == 4'(bce_pkg::CurvePoints - 1)) begin
               pct      = bce_pkg::curve_pct(seg_ff);
               state_in = bce_pkg::ST_OUT;
            end else begin
               seg_in = seg_ff + 4'd1;
            end
            if (state_in == bce_pkg::ST_OUT) begin
               mix       = ({2'b0, smooth_ff} << 1) + {2'b0, smooth_ff} + {2'b0, pct};
               smooth_in = have_ff ? mix[PW+1:2] : pct;
               have_in   = 1'b1;
            end
         end
         bce_pkg::ST_IDIV: begin
            // Multiplying by 1311/32768 divides by 25 exactly over this range.
            recip     = 22'(prod_ff[10:0]) * 22'(11'd1311);
            pct       = base_ff + recip[21:15];
            mix       = ({2'b0, smooth_ff} << 1) + {2'b0, smooth_ff} + {2'b0, pct};
            smooth_in = have_ff ? mix[PW+1:2] : pct;
            have_in   = 1'b1;
            state_in  = bce_pkg::ST_OUT;
         end
         bce_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = smooth_ff;
               state_in     = bce_pkg::ST_IDLE;
            end
         end
         default: state_in = bce_pkg::ST_IDLE;
      endcase
   end

   // A failed read leaves the smoother as it is; it is still zero before the first reading.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bce_pkg::ST_IDLE;
         smooth_ff    <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         smooth_ff    <= smooth_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff    <= prod_in;
      mv_ff      <= mv_in;
      seg_ff     <= seg_in;
      base_ff    <= base_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_charge_percent = rsp_pct_ff;

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_charge_percent <= PW'(100))
      else $error("charge percent above 100");

   a_have_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(have_ff) |-> have_ff)
      else $error("reading flag cleared");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bce_pkg::ST_IDLE) |-> req_stall)
      else $error("item taken while busy");

endmodule

@@ tb/battery_charge_estimator_test.sv @@
// Self-checking testbench of the battery charge estimator: directed and random readings.
module battery_charge_estimator_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [bce_pkg::SampleWidth-1:0] req_sample_0 = '0, req_sample_1 = '0, req_sample_2 = '0;
   logic [bce_pkg::SampleWidth-1:0] req_sample_3 = '0, req_sample_4 = '0;
   logic req_read_failed = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [bce_pkg::PctWidth-1:0] rsp_charge_percent;
   logic csr_write = 1'b0;
   logic [bce_pkg::CsrAddrWidth-1:0] csr_index = '0;
   logic [bce_pkg::CsrDataWidth-1:0] csr_data = '0;

   battery_charge_estimator u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state and register copies.
   logic [bce_pkg::RefWidth-1:0]  ref_mv;
   logic [bce_pkg::FsWidth-1:0]   full_scale;
   logic [bce_pkg::GainWidth-1:0] gain;
   logic [bce_pkg::PctWidth-1:0]  avg_pct;
   logic                          have_avg;
   logic [bce_pkg::PctWidth-1:0]  pending_pct[$];
   int errors = 0;
   bit long_stalls = 1'b0;

   localparam int MvTab[bce_pkg::CurvePoints]  = '{3300, 3500, 3600, 3700, 3750,
                                                   3800, 3900, 4000, 4100, 4200};
   localparam int PctTab[bce_pkg::CurvePoints] = '{0, 5, 10, 20, 35, 50, 70, 85, 95, 100};

   function automatic int pct_from_mv(int mv);
      if (mv <= MvTab[0]) return PctTab[0];
      for (int i = 1; i < bce_pkg::CurvePoints; i++)
         if (mv <= MvTab[i])
            return PctTab[i-1] + ((mv - MvTab[i-1]) * (PctTab[i] - PctTab[i-1])
                   + (MvTab[i] - MvTab[i-1]) / 2) / (MvTab[i] - MvTab[i-1]);
      return PctTab[bce_pkg::CurvePoints-1];
   endfunction

   function automatic logic [bce_pkg::PctWidth-1:0] next_charge(
         input logic [bce_pkg::SampleWidth-1:0] s[bce_pkg::SampleCount], input logic failed);
      int v[bce_pkg::SampleCount];
      int t, mv;
      longint pin;
      if (failed) return have_avg ? avg_pct : '0;
      foreach (s[i]) v[i] = s[i];
      for (int i = 0; i < bce_pkg::SampleCount; i++)
         for (int j = i + 1; j < bce_pkg::SampleCount; j++)
            if (v[j] < v[i]) begin t = v[i]; v[i] = v[j]; v[j] = t; end
      if (gain == 0) mv = 0;
      else if (full_scale == 0) mv = 65535;
      else begin
         pin = (longint'(v[bce_pkg::SampleCount/2]) * ref_mv) / full_scale * gain;
         mv = pin > 65535 ? 65535 : int'(pin);
      end
      t = pct_from_mv(mv);
      if (!have_avg) avg_pct = bce_pkg::PctWidth'(t);
      else avg_pct = bce_pkg::PctWidth'((3 * avg_pct + t) / 4);
      have_avg = 1'b1;
      return avg_pct;
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
                                         : int'($urandom_range(0, 2));
   endfunction

   task automatic send_reading(input logic [bce_pkg::SampleWidth-1:0] s[bce_pkg::SampleCount],
                               input logic failed, input bit idle_gaps);
      int g;
      g = idle_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_sample_0, req_sample_1, req_sample_2, req_sample_3, req_sample_4} <=
         {s[0], s[1], s[2], s[3], s[4]};
      req_read_failed <= failed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pct.push_back(next_charge(s, failed));
   endtask

   task automatic send_same(input int raw, input logic failed);
      logic [bce_pkg::SampleWidth-1:0] s[bce_pkg::SampleCount];
      foreach (s[i]) s[i] = bce_pkg::SampleWidth'(raw);
      send_reading(s, failed, 1'b0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pct.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bce_pkg::CsrAddrWidth-1:0] idx,
                            input logic [bce_pkg::CsrDataWidth-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      case (idx)
         bce_pkg::CsrRefMv:     ref_mv = d;
         bce_pkg::CsrFullScale: full_scale = d[bce_pkg::FsWidth-1:0];
         bce_pkg::CsrGain:      gain = d[bce_pkg::GainWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_scaling(input int r, input int f, input int g);
      drain();
      write_csr(bce_pkg::CsrRefMv, bce_pkg::CsrDataWidth'(r));
      write_csr(bce_pkg::CsrFullScale, bce_pkg::CsrDataWidth'(f));
      write_csr(bce_pkg::CsrGain, bce_pkg::CsrDataWidth'(g));
      csr_write <= 1'b0;
   endtask

   // Result checker; in the random phases the receiver stalls at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pct.size() == 0) begin
               $error("charge_percent: unexpected beat, actual %0d", rsp_charge_percent);
               errors++;
            end else begin
               if (rsp_charge_percent !== pending_pct[0]) begin
                  $error("charge_percent: expected %0d, actual %0d",
                         pending_pct[0], rsp_charge_percent);
                  errors++;
               end
               void'(pending_pct.pop_front());
            end
         end
         if (!long_stalls) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 19) == 0) rsp_stall <= 1'b1;
         else if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   task automatic test_failure_before_reading();
      send_same(1000, 1'b1);
      send_same(0, 1'b1);
   endtask

   task automatic test_curve_points();
      // Default scaling: 2*3300/2047 mV per code; sweep through every segment but 3750-3800 mV.
      int codes[] = '{0, 2047, 1023, 1070, 1100, 1120, 1150, 1160, 1180, 1200,
                      1240, 1270, 1290, 1310};
      foreach (codes[i]) send_same(codes[i], 1'b0);
      send_same(2047, 1'b1);
   endtask

   task automatic test_median_order();
      logic [bce_pkg::SampleWidth-1:0] s[bce_pkg::SampleCount];
      s = '{2047, 0, 1200, 1100, 1300};
      send_reading(s, 1'b0, 1'b0);
      s = '{1, 2, 2046, 2047, 5};
      send_reading(s, 1'b0, 1'b0);
   endtask

   task automatic test_scaling_extremes();
      set_scaling(5000, 1, 8);      // saturates at 65535 mV
      send_same(2047, 1'b0);
      send_same(0, 1'b0);
      set_scaling(1, 4095, 1);
      send_same(2047, 1'b0);
      set_scaling(8191, 0, 15);     // zero full scale reads saturated
      send_same(5, 1'b0);
      set_scaling(3300, 2047, 0);   // zero gain reads empty
      send_same(2047, 1'b0);
   endtask

   task automatic random_phase(input int n, input int r, input int f, input int g);
      logic [bce_pkg::SampleWidth-1:0] s[bce_pkg::SampleCount];
      int centre;
      set_scaling(r, f, g);
      long_stalls = 1'b1;
      for (int k = 0; k < n; k++) begin
         // Mostly samples clustered around a code inside the curve.
         centre = (f == 0) ? int'($urandom_range(0, 2047))
                 : int'(longint'(3200 + $urandom_range(0, 1100)) * f / r
                        / ((g != 0) ? g : 1));
         if (centre > 2047 || $urandom_range(0, 7) == 0) centre = int'($urandom_range(0, 2047));
         foreach (s[i])
            s[i] = ($urandom_range(0, 9) == 0) ? bce_pkg::SampleWidth'($urandom_range(0, 2047))
                 : bce_pkg::SampleWidth'((centre + $urandom_range(0, 20) - 10) & 11'h7FF);
         send_reading(s, ($urandom_range(0, 9) == 0), (k % 200) < 150);
      end
      long_stalls = 1'b0;
   endtask

   task automatic test_random();
      random_phase(400, 3300, 2047, 2);
      random_phase(250, 2500, 4095, 4);
      random_phase(250, $urandom_range(1, 5000), $urandom_range(1, 4095),
                   $urandom_range(1, 8));
      random_phase(200, 5000, 1, 8);
      random_phase(150, 1, 4095, 1);
      random_phase(150, 4200, 2800, 3);
   endtask

   initial begin
      ref_mv = 3300;
      full_scale = 2047;
      gain = 2;
      avg_pct = '0;
      have_avg = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_failure_before_reading();
      test_curve_points();
      test_median_order();
      test_scaling_extremes();
      test_random();
      drain();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
